/* sv/pws_pkg.sv */
// pws_pkg: shared types, constants, suffix rule tables and helpers
// for the word stemmer. Depends on nothing.
`default_nettype none

package pws_pkg;

    localparam int unsigned MAX_WORD_DEF = 31;
    localparam int unsigned WORD_DEPTH   = 32;
    localparam int unsigned IDX_W        = 5;
    localparam int unsigned LEN_W        = 6;
    localparam int unsigned MEAS_W       = 5;
    localparam int unsigned MAP_VOWEL    = 7;
    localparam int unsigned MAP_CC       = 6;
    localparam int unsigned MAP_CVC      = 5;
    localparam int unsigned TAIL_N       = 8;

    typedef logic [7:0] char_t;
    typedef char_t [WORD_DEPTH-1:0] word_t;

    typedef struct packed {
        word_t            word;
        logic [LEN_W-1:0] len;
        logic             err;
    } q_entry_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MAP,
        B_EXEC,
        B_EMIT
    } back_state_t;

    typedef enum logic [3:0] {
        ST_1A,
        ST_1B,
        ST_1B2,
        ST_1C,
        ST_2,
        ST_3,
        ST_4,
        ST_5A,
        ST_5B
    } step_t;

    typedef struct packed {
        logic [55:0] suf;
        logic [2:0]  n;
        logic [31:0] rep;
        logic [2:0]  rn;
        logic [3:0]  minlen;
        logic        st;
    } rule_t;

    function automatic logic is_vowel(input char_t c);
        return (c == "A") || (c == "E") || (c == "I") || (c == "O") || (c == "U");
    endfunction

    function automatic rule_t rule_1a(input logic [4:0] k);
        rule_t r;
        case (k)
            5'd0:    r = '{"SSES", 3'd4, "SS", 3'd2, 4'd0, 1'b0};
            5'd1:    r = '{"IES", 3'd3, "I", 3'd1, 4'd0, 1'b0};
            5'd2:    r = '{"SS", 3'd2, "SS", 3'd2, 4'd0, 1'b0};
            default: r = '{"S", 3'd1, 32'h0, 3'd0, 4'd0, 1'b0};
        endcase
        return r;
    endfunction

    function automatic rule_t rule_2(input logic [4:0] k);
        rule_t r;
        case (k)
            5'd0:    r = '{"ENCI", 3'd4, "ENCE", 3'd4, 4'd0, 1'b0};
            5'd1:    r = '{"ANCI", 3'd4, "ANCE", 3'd4, 4'd0, 1'b0};
            5'd2:    r = '{"ABLI", 3'd4, "ABLE", 3'd4, 4'd0, 1'b0};
            5'd3:    r = '{"ALLI", 3'd4, "AL", 3'd2, 4'd0, 1'b0};
            5'd4:    r = '{"ENTLI", 3'd5, "ENT", 3'd3, 4'd0, 1'b0};
            5'd5:    r = '{"ELI", 3'd3, "E", 3'd1, 4'd0, 1'b0};
            5'd6:    r = '{"OUSLI", 3'd5, "OUS", 3'd3, 4'd0, 1'b0};
            5'd7:    r = '{"ALITI", 3'd5, "AL", 3'd2, 4'd0, 1'b0};
            5'd8:    r = '{"IVITI", 3'd5, "IVE", 3'd3, 4'd0, 1'b0};
            5'd9:    r = '{"BILITI", 3'd6, "BLE", 3'd3, 4'd0, 1'b0};
            5'd10:   r = '{"ATIONAL", 3'd7, "ATE", 3'd3, 4'd0, 1'b0};
            5'd11:   r = '{"TIONAL", 3'd6, "TION", 3'd4, 4'd0, 1'b0};
            5'd12:   r = '{"ALISM", 3'd5, "AL", 3'd2, 4'd0, 1'b0};
            5'd13:   r = '{"IZATION", 3'd7, "IZE", 3'd3, 4'd6, 1'b0};
            5'd14:   r = '{"ATION", 3'd5, "ATE", 3'd3, 4'd6, 1'b0};
            5'd15:   r = '{"IZER", 3'd4, "IZE", 3'd3, 4'd6, 1'b0};
            5'd16:   r = '{"ATOR", 3'd4, "ATE", 3'd3, 4'd6, 1'b0};
            5'd17:   r = '{"IVENESS", 3'd7, "IVE", 3'd3, 4'd9, 1'b0};
            5'd18:   r = '{"FULNESS", 3'd7, "FUL", 3'd3, 4'd9, 1'b0};
            default: r = '{"OUSNESS", 3'd7, "OUS", 3'd3, 4'd9, 1'b0};
        endcase
        return r;
    endfunction

    function automatic rule_t rule_3(input logic [4:0] k);
        rule_t r;
        case (k)
            5'd0:    r = '{"ICATE", 3'd5, "IC", 3'd2, 4'd7, 1'b0};
            5'd1:    r = '{"ATIVE", 3'd5, 32'h0, 3'd0, 4'd7, 1'b0};
            5'd2:    r = '{"ALIZE", 3'd5, "AL", 3'd2, 4'd7, 1'b0};
            5'd3:    r = '{"ICITI", 3'd5, "IC", 3'd2, 4'd6, 1'b0};
            5'd4:    r = '{"ICAL", 3'd4, "IC", 3'd2, 4'd6, 1'b0};
            5'd5:    r = '{"FUL", 3'd3, 32'h0, 3'd0, 4'd5, 1'b0};
            default: r = '{"NESS", 3'd4, 32'h0, 3'd0, 4'd6, 1'b0};
        endcase
        return r;
    endfunction

    function automatic rule_t rule_4(input logic [4:0] k);
        rule_t r;
        case (k)
            5'd0:    r = '{"IC", 3'd2, 32'h0, 3'd0, 4'd5, 1'b0};
            5'd1:    r = '{"ANCE", 3'd4, 32'h0, 3'd0, 4'd7, 1'b0};
            5'd2:    r = '{"ENCE", 3'd4, 32'h0, 3'd0, 4'd7, 1'b0};
            5'd3:    r = '{"ABLE", 3'd4, 32'h0, 3'd0, 4'd7, 1'b0};
            5'd4:    r = '{"IBLE", 3'd4, 32'h0, 3'd0, 4'd7, 1'b0};
            5'd5:    r = '{"ATE", 3'd3, 32'h0, 3'd0, 4'd6, 1'b0};
            5'd6:    r = '{"IVE", 3'd3, 32'h0, 3'd0, 4'd6, 1'b0};
            5'd7:    r = '{"IZE", 3'd3, 32'h0, 3'd0, 4'd6, 1'b0};
            5'd8:    r = '{"ITI", 3'd3, 32'h0, 3'd0, 4'd6, 1'b0};
            5'd9:    r = '{"AL", 3'd2, 32'h0, 3'd0, 4'd5, 1'b0};
            5'd10:   r = '{"ISM", 3'd3, 32'h0, 3'd0, 4'd6, 1'b0};
            5'd11:   r = '{"ER", 3'd2, 32'h0, 3'd0, 4'd5, 1'b0};
            5'd12:   r = '{"ANT", 3'd3, 32'h0, 3'd0, 4'd8, 1'b0};
            5'd13:   r = '{"EMENT", 3'd5, 32'h0, 3'd0, 4'd8, 1'b0};
            5'd14:   r = '{"MENT", 3'd4, 32'h0, 3'd0, 4'd8, 1'b0};
            5'd15:   r = '{"ENT", 3'd3, 32'h0, 3'd0, 4'd8, 1'b0};
            5'd16:   r = '{"ION", 3'd3, 32'h0, 3'd0, 4'd7, 1'b1};
            5'd17:   r = '{"OUS", 3'd3, 32'h0, 3'd0, 4'd6, 1'b0};
            default: r = '{"OU", 3'd2, 32'h0, 3'd0, 4'd5, 1'b0};
        endcase
        return r;
    endfunction

    function automatic rule_t rule_get(input step_t s, input logic [4:0] k);
        rule_t r;
        case (s)
            ST_1A:   r = rule_1a(k);
            ST_2:    r = rule_2(k);
            ST_3:    r = rule_3(k);
            default: r = rule_4(k);
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rule_count(input step_t s);
        logic [4:0] c;
        case (s)
            ST_1A:   c = 5'd4;
            ST_2:    c = 5'd20;
            ST_3:    c = 5'd7;
            default: c = 5'd19;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/pws_front.sv */
// pws_front: takes characters, folds case, collects the word and hands
// finished words to the queue. Depends on pws_pkg.
`default_nettype none

module pws_front #(
    parameter int unsigned MAX_WORD = pws_pkg::MAX_WORD_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire pws_pkg::char_t    in_char,
    input  wire logic              word_end,
    input  wire logic              q_full,
    output logic                   q_push,
    output pws_pkg::q_entry_t      q_data
);

    pws_pkg::word_t                 wbuf_reg;
    logic [pws_pkg::LEN_W-1:0]      wlen_reg;
    logic [pws_pkg::LEN_W-1:0]      wlen_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic                           take;
    logic                           store;
    pws_pkg::char_t                 c_up;
    pws_pkg::word_t                 merged;

    assign full = q_full;
    assign take = push && !full;

    always_comb
    begin
        c_up = (in_char >= "a" && in_char <= "z") ? in_char - 8'd32 : in_char;
        store = take && (in_char != 8'h00) && (wlen_reg < pws_pkg::LEN_W'(MAX_WORD));
        wlen_next = wlen_reg + pws_pkg::LEN_W'(store);
        ovf_next = ovf_reg | (take && (in_char != 8'h00) && !store);
        merged = wbuf_reg;
        if (store)
        begin
            merged[wlen_reg[pws_pkg::IDX_W-1:0]] = c_up;
        end
        q_push = take && word_end;
        q_data.word = merged;
        q_data.len = wlen_next;
        q_data.err = ovf_next || (wlen_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            wbuf_reg[wlen_reg[pws_pkg::IDX_W-1:0]] <= c_up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (word_end)
            begin
                wlen_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                wlen_reg <= wlen_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/pws_queue.sv */
// pws_queue: two-entry word queue between the front and the stemming
// sequencer. Depends on pws_pkg.
`default_nettype none

module pws_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire pws_pkg::q_entry_t   wr_data,
    output logic                     q_full,
    input  wire logic                rd_en,
    output pws_pkg::q_entry_t        rd_data,
    output logic                     q_empty
);

    pws_pkg::q_entry_t slot_reg [2];
    logic              wptr_reg;
    logic              rptr_reg;
    logic [1:0]        cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

`default_nettype wire

/* sv/pws_back.sv */
// pws_back: stemming sequencer; rebuilds the measure map one entry per cycle,
// walks suffix rules one per cycle and emits the stem. Depends on pws_pkg.
`default_nettype none

module pws_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire pws_pkg::q_entry_t   q_data,
    output logic                     q_pop,
    output logic                     empty,
    input  wire logic                pop,
    output pws_pkg::char_t           out_char,
    output logic                     out_last,
    output logic                     status
);

    pws_pkg::back_state_t           state_reg, state_next;
    pws_pkg::step_t                 step_reg, step_next, step_after;
    pws_pkg::word_t                 word_reg, word_next;
    pws_pkg::char_t                 map_reg [pws_pkg::WORD_DEPTH];
    logic [pws_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [pws_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [4:0]                     rule_reg, rule_next;
    logic                           err_reg, err_next;
    logic                           out_valid_reg, out_valid_next;
    pws_pkg::char_t                 out_char_reg, out_char_next;
    logic                           out_last_reg, out_last_next;
    logic                           status_reg, status_next;
    logic                           map_we;
    logic                           slot_free;
    logic                           step_done;
    pws_pkg::char_t                 tail [pws_pkg::TAIL_N];
    logic [6:0]                     lx;
    logic [6:0]                     ix;
    pws_pkg::char_t                 c0, c1, c2, c3;
    logic                           gt0, gt1, gt2, cur, prev, v2;
    pws_pkg::char_t                 pm, ent;
    logic [pws_pkg::MEAS_W-1:0]     msum;
    pws_pkg::rule_t                 rl;
    logic                           matched, ok;
    logic [6:0]                     at;
    pws_pkg::char_t                 m_at, c_at, m1, m2, m3, m4;
    logic [pws_pkg::LEN_W-1:0]      base;
    logic [pws_pkg::LEN_W-1:0]      wa;
    logic [2:0]                     sh;

    function automatic pws_pkg::char_t rdc(input pws_pkg::word_t w, input logic [6:0] i);
        return i[6] ? 8'h00 : w[i[pws_pkg::IDX_W-1:0]];
    endfunction

    function automatic pws_pkg::char_t rdm(input pws_pkg::char_t m [pws_pkg::WORD_DEPTH],
                                           input logic [6:0] i);
        return i[6] ? 8'h00 : m[i[pws_pkg::IDX_W-1:0]];
    endfunction

    assign slot_free = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign status    = status_reg;

    // word tail, map entry for the current position and suffix rule checks
    always_comb
    begin
        lx = {1'b0, len_reg};
        for (int j = 0; j < pws_pkg::TAIL_N; j++)
        begin
            tail[j] = rdc(word_reg, lx - 7'(j) - 7'd1);
        end
        m1 = rdm(map_reg, lx - 7'd1);
        m2 = rdm(map_reg, lx - 7'd2);
        m3 = rdm(map_reg, lx - 7'd3);
        m4 = rdm(map_reg, lx - 7'd4);

        ix = {2'b00, idx_reg};
        c0 = rdc(word_reg, ix);
        c1 = rdc(word_reg, ix - 7'd1);
        c2 = rdc(word_reg, ix - 7'd2);
        c3 = rdc(word_reg, ix - 7'd3);
        gt0 = (idx_reg != '0);
        gt1 = (idx_reg > 5'd1);
        gt2 = (idx_reg > 5'd2);
        cur = pws_pkg::is_vowel(c0) || (c0 == "Y" && gt0 && !pws_pkg::is_vowel(c1));
        prev = gt0 && (pws_pkg::is_vowel(c1) || (c1 == "Y" && gt1 && !pws_pkg::is_vowel(c2)));
        v2 = gt1 && (pws_pkg::is_vowel(c2) || (c2 == "Y" && gt2 && !pws_pkg::is_vowel(c3)));
        pm = rdm(map_reg, ix - 7'd1);
        msum = pm[pws_pkg::MEAS_W-1:0] + pws_pkg::MEAS_W'(prev && !cur);
        ent = {pm[pws_pkg::MAP_VOWEL] | cur, 2'b00, msum};
        if (!cur)
        begin
            if (!prev && gt0 && c0 == c1)
            begin
                ent[pws_pkg::MAP_CC] = 1'b1;
            end
            else if (gt1 && prev && c0 != "W" && c0 != "X" && c0 != "Y" && !v2)
            begin
                ent[pws_pkg::MAP_CVC] = 1'b1;
            end
        end

        rl = pws_pkg::rule_get(step_reg, rule_reg);
        matched = (len_reg >= {3'b000, rl.n});
        for (int j = 0; j < 7; j++)
        begin
            if (3'(j) < rl.n && tail[j] != rl.suf[8*j +: 8])
            begin
                matched = 1'b0;
            end
        end
        at = lx - {4'b0000, rl.n} - 7'd1;
        m_at = rdm(map_reg, at);
        c_at = tail[rl.n];
        case (step_reg)
            pws_pkg::ST_1A: ok = 1'b1;
            pws_pkg::ST_2, pws_pkg::ST_3: ok = (m_at[pws_pkg::MEAS_W-1:0] != '0);
            default: ok = (m_at[pws_pkg::MEAS_W-1:0] > 5'd1)
                          && (!rl.st || c_at == "S" || c_at == "T");
        endcase
        ok = ok && (len_reg >= {2'b00, rl.minlen});
        base = len_reg - {3'b000, rl.n};
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        step_after = pws_pkg::step_t'(step_reg + 4'd1);
        step_done = 1'b0;
        len_next = len_reg;
        idx_next = idx_reg;
        rule_next = rule_reg;
        err_next = err_reg;
        word_next = word_reg;
        map_we = 1'b0;
        q_pop = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        status_next = status_reg;
        wa = '0;
        sh = '0;
        case (state_reg)
            pws_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    word_next = q_data.word;
                    len_next = q_data.len;
                    err_next = q_data.err;
                    step_next = pws_pkg::ST_1A;
                    idx_next = '0;
                    rule_next = '0;
                    state_next = q_data.err ? pws_pkg::B_EMIT : pws_pkg::B_MAP;
                end
            end
            pws_pkg::B_MAP:
            begin
                rule_next = '0;
                if (len_reg == '0)
                begin
                    state_next = pws_pkg::B_EXEC;
                end
                else
                begin
                    map_we = 1'b1;
                    if ({1'b0, idx_reg} == len_reg - 6'd1)
                    begin
                        state_next = pws_pkg::B_EXEC;
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            pws_pkg::B_EXEC:
            begin
                case (step_reg)
                    pws_pkg::ST_1A, pws_pkg::ST_2, pws_pkg::ST_3, pws_pkg::ST_4:
                    begin
                        if (matched)
                        begin
                            if (ok)
                            begin
                                for (int i = 0; i < 4; i++)
                                begin
                                    if (3'(i) < rl.rn)
                                    begin
                                        sh = rl.rn - 3'(i) - 3'd1;
                                        wa = base + 6'(i);
                                        word_next[wa[pws_pkg::IDX_W-1:0]] =
                                            rl.rep[{sh[1:0], 3'b000} +: 8];
                                    end
                                end
                                len_next = base + {3'b000, rl.rn};
                            end
                            step_done = 1'b1;
                        end
                        else if (rule_reg == pws_pkg::rule_count(step_reg) - 5'd1)
                        begin
                            step_done = 1'b1;
                        end
                        else
                        begin
                            rule_next = rule_reg + 5'd1;
                        end
                    end
                    pws_pkg::ST_1B:
                    begin
                        step_after = pws_pkg::ST_1C;
                        if (tail[0] == "D" && tail[1] == "E" && tail[2] == "E")
                        begin
                            if (len_reg > 6'd4 && m4[pws_pkg::MEAS_W-1:0] != '0)
                            begin
                                len_next = len_reg - 6'd1;
                            end
                            step_done = 1'b1;
                        end
                        else if (tail[0] == "D" && tail[1] == "E")
                        begin
                            if (m3[pws_pkg::MAP_VOWEL])
                            begin
                                len_next = len_reg - 6'd2;
                                step_next = pws_pkg::ST_1B2;
                            end
                            else
                            begin
                                step_done = 1'b1;
                            end
                        end
                        else if (tail[0] == "G" && tail[1] == "N" && tail[2] == "I")
                        begin
                            if (m4[pws_pkg::MAP_VOWEL])
                            begin
                                len_next = len_reg - 6'd3;
                                step_next = pws_pkg::ST_1B2;
                            end
                            else
                            begin
                                step_done = 1'b1;
                            end
                        end
                        else
                        begin
                            step_done = 1'b1;
                        end
                    end
                    pws_pkg::ST_1B2:
                    begin
                        if ((tail[0] == "T" && tail[1] == "A")
                            || (tail[0] == "L" && tail[1] == "B")
                            || (tail[0] == "Z" && tail[1] == "I"))
                        begin
                            word_next[len_reg[pws_pkg::IDX_W-1:0]] = "E";
                            len_next = len_reg + 6'd1;
                        end
                        else if (len_reg > 6'd1 && m1[pws_pkg::MAP_CC]
                                 && tail[0] != "L" && tail[0] != "S" && tail[0] != "Z")
                        begin
                            len_next = len_reg - 6'd1;
                        end
                        else if (m1[pws_pkg::MEAS_W-1:0] == 5'd1 && m1[pws_pkg::MAP_CVC])
                        begin
                            word_next[len_reg[pws_pkg::IDX_W-1:0]] = "E";
                            len_next = len_reg + 6'd1;
                        end
                        step_done = 1'b1;
                    end
                    pws_pkg::ST_1C:
                    begin
                        if (tail[0] == "Y" && m2[pws_pkg::MAP_VOWEL])
                        begin
                            wa = len_reg - 6'd1;
                            word_next[wa[pws_pkg::IDX_W-1:0]] = "I";
                        end
                        step_done = 1'b1;
                    end
                    pws_pkg::ST_5A:
                    begin
                        if (tail[0] == "E" && len_reg >= 6'd3)
                        begin
                            if (m2[pws_pkg::MEAS_W-1:0] > 5'd1)
                            begin
                                len_next = len_reg - 6'd1;
                            end
                            else if (!m2[pws_pkg::MAP_CVC] && m2[pws_pkg::MEAS_W-1:0] == 5'd1)
                            begin
                                len_next = len_reg - 6'd1;
                            end
                        end
                        step_done = 1'b1;
                    end
                    pws_pkg::ST_5B:
                    begin
                        if (tail[0] == "L" && tail[1] == "L" && m1[pws_pkg::MEAS_W-1:0] > 5'd1)
                        begin
                            len_next = len_reg - 6'd1;
                        end
                        step_done = 1'b1;
                    end
                    default:
                    begin
                        step_done = 1'b1;
                    end
                endcase
                if (step_done)
                begin
                    idx_next = '0;
                    rule_next = '0;
                    if (step_reg == pws_pkg::ST_5B)
                    begin
                        state_next = pws_pkg::B_EMIT;
                    end
                    else
                    begin
                        step_next = step_after;
                        state_next = pws_pkg::B_MAP;
                    end
                end
            end
            pws_pkg::B_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg || len_reg == '0)
                    begin
                        out_char_next = 8'h00;
                        out_last_next = 1'b1;
                        status_next = err_reg;
                        state_next = pws_pkg::B_IDLE;
                    end
                    else
                    begin
                        out_char_next = word_reg[idx_reg];
                        status_next = 1'b0;
                        out_last_next = ({1'b0, idx_reg} == len_reg - 6'd1);
                        if ({1'b0, idx_reg} == len_reg - 6'd1)
                        begin
                            state_next = pws_pkg::B_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 5'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = pws_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        len_reg <= len_next;
        idx_reg <= idx_next;
        rule_reg <= rule_next;
        step_reg <= step_next;
        err_reg <= err_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        status_reg <= status_next;
        if (map_we)
        begin
            map_reg[idx_reg] <= ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pws_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_map_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pws_pkg::B_MAP && len_reg != '0) |-> ({1'b0, idx_reg} < len_reg))
        else $error("map pass index beyond word");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pws_pkg::B_EMIT && !err_reg && len_reg != '0)
        |-> ({1'b0, idx_reg} < len_reg))
        else $error("emit index beyond stem");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (out_last_reg && out_char_reg == 8'h00))
        else $error("error transaction not single");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pws_pkg::B_EXEC) |-> (len_reg <= 6'd31))
        else $error("word length out of range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == pws_pkg::B_IDLE && !q_empty))
        else $error("queue read outside idle");

endmodule

`default_nettype wire

/* sv/porter_word_stemmer.sv */
// Porter word stemmer. Characters are taken one per cycle while full is
// low (push/full) and folded to upper case; at the character marked
// word_end the word goes to a two-word queue while the next word may
// already load. The stemming unit then runs up to nine passes (steps 1a,
// 1b, 1b tail, 1c, 2, 3, 4, 5a, 5b); all but the 1b tail are preceded by
// a measure-map rebuild of one entry per character, the rule-list steps
// check one suffix per cycle, and the stem is emitted one character per
// cycle while the output slot is free (empty/pop). The stemming unit
// loads the word, then runs eight serial map rebuilds and up to 55 rule
// and step checks, then emits the stem. Empty or overlong words give one
// transaction with status 1.
// Depends on pws_pkg, pws_front, pws_queue and pws_back.
`default_nettype none

module porter_word_stemmer #(
    parameter int unsigned MAX_WORD = pws_pkg::MAX_WORD_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [7:0]     in_char,
    input  wire logic           word_end,
    output logic                empty,
    input  wire logic           pop,
    output logic [7:0]          out_char,
    output logic                out_last,
    output logic                status
);

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    pws_pkg::q_entry_t q_wdata;
    pws_pkg::q_entry_t q_rdata;

    pws_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_char  (in_char),
        .word_end (word_end),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    pws_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    pws_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_char (out_char),
        .out_last (out_last),
        .status   (status)
    );

endmodule

`default_nettype wire
